// ===== src/owtr_pkg.sv =====
// Shared constants for the one-wire temperature reader: widths, command codes, ROM commands.
package owtr_pkg;

  localparam int CounterBits = 20;

  // Command codes on the input tuser field
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_RESET     = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_READ      = 3'd3;
  localparam logic [2:0] CMD_TEMP_READ = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [2:0] REG_PRESENCE_WIN  = 3'd2;
  localparam logic [2:0] REG_WRITE_SLOT    = 3'd3;
  localparam logic [2:0] REG_READ_RECOVERY = 3'd4;
  localparam logic [2:0] REG_CONV_WAIT     = 3'd5;

  // Bus command bytes
  localparam logic [7:0] SKIP_ROM  = 8'hCC;
  localparam logic [7:0] CONVERT_T = 8'h44;
  localparam logic [7:0] READ_PAD  = 8'hBE;

  // Fixed phase lengths in ticks
  localparam logic [CounterBits-1:0] PRE_HIGH_TICKS = CounterBits'(50);
  localparam logic [CounterBits-1:0] RECOVERY_TICKS = CounterBits'(10);
  localparam logic [CounterBits-1:0] START_TICKS    = CounterBits'(1);
  localparam logic [CounterBits-1:0] TAIL_TICKS     = CounterBits'(100);

  // Temperature sequence steps
  localparam logic [3:0] STEP_NONE     = 4'd0;
  localparam logic [3:0] STEP_FIRST    = 4'd1;
  localparam logic [3:0] STEP_RESET_A  = 4'd1;
  localparam logic [3:0] STEP_SKIP_A   = 4'd2;
  localparam logic [3:0] STEP_CONVERT  = 4'd3;
  localparam logic [3:0] STEP_WAIT     = 4'd4;
  localparam logic [3:0] STEP_RESET_B  = 4'd5;
  localparam logic [3:0] STEP_SKIP_B   = 4'd6;
  localparam logic [3:0] STEP_READ_PAD = 4'd7;
  localparam logic [3:0] STEP_LOW_BYTE = 4'd8;
  localparam logic [3:0] STEP_HI_BYTE  = 4'd9;
  localparam logic [3:0] STEP_LAST     = 4'd10;

endpackage

// ===== src/one_wire_temperature_reader.sv =====
// One-wire bus master with a built-in temperature read sequence, one tick per beat.
//
// Input channel s_*: each beat is one bus tick of one microsecond. s_tuser carries the
// command (none, reset pulse, write byte, read byte, temperature read), s_tdata the
// byte to write and the sampled line level. A command is taken only while the master
// is idle; commands that arrive while busy are dropped.
// Output channel m_*: one beat per input beat, with the line drive for that tick
// (pull low, output enable), busy/done status, the last byte read and the last
// temperature (signed, 1/16 degree) with a one-beat valid flag.
// Each output beat is registered from its input beat; throughput is one beat per
// cycle while the receiver takes each beat. The whole tick update is one pass of
// logic between the state registers and the output register.
// When the receiver stalls, the output register holds its beat and s_tready drops
// only if that beat is not taken in the same cycle.
// Reset (rst, synchronous) returns the master to idle, clears the held bytes and
// loads the default timing registers. Timing registers are written over cfg_*; the
// user must write them only while idle, which the block itself does not enforce.
module one_wire_temperature_reader
  import owtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // write_byte[7:0], line_level[8], zero[15:9]
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // line_drive_low[0], line_output_enable[1], busy_res[2],
                                 // done_res[3], read_byte[11:4], temperature[27:12],
                                 // temperature_valid[28], zero[31:29]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_PRE, PH_RST_LOW, PH_RST_REL, PH_RST_WIN,
    PH_WR_REC, PH_WR_START, PH_WR_BIT,
    PH_RD_REC, PH_RD_START, PH_RD_SAMPLE,
    PH_CONV, PH_TAIL
  } phase_t;

  localparam int CB = CounterBits;

  // timing registers
  logic [9:0]  reset_low_time, reset_release_time, presence_window_time;
  logic [7:0]  write_slot_time, read_recovery_time;
  logic [19:0] conversion_wait_time;

  // master state
  phase_t         phase, phase_next;
  logic [CB-1:0]  tick_counter, tick_counter_next;
  logic [2:0]     bit_counter, bit_counter_next;
  logic [7:0]     shift_byte, shift_byte_next;
  logic [3:0]     sequence_step, sequence_step_next;
  logic [7:0]     low_byte_hold, low_byte_hold_next;
  logic [15:0]    temperature_hold, temperature_hold_next;
  logic [7:0]     last_read, last_read_next;

  logic           in_beat;
  logic [2:0]     cmd;
  logic [7:0]     write_byte;
  logic           line_level;

  logic           drive_low, out_enable, busy, done_flag, valid_flag;
  logic           finish;
  logic [3:0]     step_new;
  logic [CB-1:0]  cur_len;
  logic [CB:0]    count_inc;

  assign cmd        = s_tuser;
  assign write_byte = s_tdata[7:0];
  assign line_level = s_tdata[8];

  assign s_tready = !m_tvalid || m_tready;
  assign in_beat  = s_tvalid && s_tready;

  function automatic logic [CB-1:0] min_one(input logic [CB-1:0] v);
    min_one = (v == '0) ? CB'(1) : v;
  endfunction

  function automatic logic [CB-1:0] phase_len(input phase_t p,
                                              input logic [9:0] rlow,
                                              input logic [9:0] rrel,
                                              input logic [9:0] rwin,
                                              input logic [7:0] wslot,
                                              input logic [7:0] rrec,
                                              input logic [19:0] conv);
    case (p)
      PH_RST_PRE:            phase_len = PRE_HIGH_TICKS;
      PH_RST_LOW:            phase_len = min_one(CB'(rlow));
      PH_RST_REL:            phase_len = CB'(rrel);
      PH_RST_WIN:            phase_len = CB'(rwin);
      PH_WR_REC, PH_RD_REC:  phase_len = RECOVERY_TICKS;
      PH_WR_START,
      PH_RD_START:           phase_len = START_TICKS;
      PH_WR_BIT:             phase_len = min_one(CB'(wslot));
      PH_RD_SAMPLE:          phase_len = min_one(CB'(rrec));
      PH_CONV: begin
        // saturate a wait that does not fit the tick counter
        if ((32'(conv) >> CB) != 32'd0) phase_len = '1;
        else                            phase_len = CB'(conv);
      end
      PH_TAIL:               phase_len = TAIL_TICKS;
      default:               phase_len = CB'(1);
    endcase
  endfunction

  always_comb begin
    phase_next            = phase;
    tick_counter_next     = tick_counter;
    bit_counter_next      = bit_counter;
    shift_byte_next       = shift_byte;
    sequence_step_next    = sequence_step;
    low_byte_hold_next    = low_byte_hold;
    temperature_hold_next = temperature_hold;
    last_read_next        = last_read;
    done_flag             = 1'b0;
    valid_flag            = 1'b0;
    finish                = 1'b0;
    step_new              = sequence_step;

    // start a command on the same tick it arrives
    if (phase == PH_IDLE) begin
      case (cmd)
        CMD_RESET: begin
          sequence_step_next = STEP_NONE;
          phase_next = PH_RST_PRE;
          tick_counter_next = '0;
          bit_counter_next = '0;
          shift_byte_next = '0;
        end
        CMD_WRITE: begin
          sequence_step_next = STEP_NONE;
          phase_next = PH_WR_REC;
          tick_counter_next = '0;
          bit_counter_next = '0;
          shift_byte_next = write_byte;
        end
        CMD_READ: begin
          sequence_step_next = STEP_NONE;
          phase_next = PH_RD_REC;
          tick_counter_next = '0;
          bit_counter_next = '0;
          shift_byte_next = '0;
        end
        CMD_TEMP_READ: begin
          sequence_step_next = STEP_FIRST;
          phase_next = PH_RST_PRE;
          tick_counter_next = '0;
          bit_counter_next = '0;
          shift_byte_next = '0;
        end
        default: ;
      endcase
    end

    drive_low  = 1'b0;
    out_enable = 1'b1;
    case (phase_next)
      PH_RST_LOW, PH_WR_START, PH_RD_START: drive_low = 1'b1;
      PH_RST_WIN, PH_RD_SAMPLE:             out_enable = 1'b0;
      PH_WR_BIT:                            drive_low = !shift_byte_next[0];
      default: ;
    endcase
    busy = (phase_next != PH_IDLE);

    cur_len = phase_len(phase_next, reset_low_time, reset_release_time,
                        presence_window_time, write_slot_time, read_recovery_time,
                        conversion_wait_time);
    count_inc = {1'b0, tick_counter_next} + (CB+1)'(1);

    if (busy) begin
      if (phase_next == PH_RD_SAMPLE && tick_counter_next == '0) begin
        shift_byte_next = {line_level, shift_byte_next[7:1]};
      end
      tick_counter_next = count_inc[CB-1:0];
      if (count_inc >= {1'b0, cur_len}) begin
        tick_counter_next = '0;
        case (phase_next)
          PH_RST_PRE: phase_next = PH_RST_LOW;
          PH_RST_LOW: begin
            // skip zero-length release and window phases
            if (reset_release_time != '0)        phase_next = PH_RST_REL;
            else if (presence_window_time != '0) phase_next = PH_RST_WIN;
            else                                 finish = 1'b1;
          end
          PH_RST_REL: begin
            if (presence_window_time != '0) phase_next = PH_RST_WIN;
            else                            finish = 1'b1;
          end
          PH_WR_REC:   phase_next = PH_WR_START;
          PH_WR_START: phase_next = PH_WR_BIT;
          PH_WR_BIT: begin
            shift_byte_next = {1'b0, shift_byte_next[7:1]};
            if (bit_counter_next == 3'd7) begin
              finish = 1'b1;
            end else begin
              bit_counter_next = bit_counter_next + 3'd1;
              phase_next = PH_WR_REC;
            end
          end
          PH_RD_REC:   phase_next = PH_RD_START;
          PH_RD_START: phase_next = PH_RD_SAMPLE;
          PH_RD_SAMPLE: begin
            if (bit_counter_next == 3'd7) begin
              last_read_next = shift_byte_next;
              if (sequence_step_next == STEP_LOW_BYTE) low_byte_hold_next = shift_byte_next;
              finish = 1'b1;
            end else begin
              bit_counter_next = bit_counter_next + 3'd1;
              phase_next = PH_RD_REC;
            end
          end
          default: finish = 1'b1;
        endcase
      end
    end

    if (finish) begin
      if (sequence_step_next == STEP_NONE || sequence_step_next >= STEP_LAST) begin
        if (sequence_step_next >= STEP_LAST) begin
          temperature_hold_next = {last_read_next, low_byte_hold_next};
          valid_flag = 1'b1;
        end
        done_flag = 1'b1;
        sequence_step_next = STEP_NONE;
        phase_next = PH_IDLE;
        tick_counter_next = '0;
      end else begin
        step_new = sequence_step_next + 4'd1;
        // a zero conversion wait falls straight through to the second reset
        if (step_new == STEP_WAIT && conversion_wait_time == '0) step_new = STEP_RESET_B;
        sequence_step_next = step_new;
        tick_counter_next = '0;
        bit_counter_next = '0;
        shift_byte_next = '0;
        case (step_new)
          STEP_RESET_A, STEP_RESET_B: phase_next = PH_RST_PRE;
          STEP_SKIP_A, STEP_SKIP_B: begin
            phase_next = PH_WR_REC;
            shift_byte_next = SKIP_ROM;
          end
          STEP_CONVERT: begin
            phase_next = PH_WR_REC;
            shift_byte_next = CONVERT_T;
          end
          STEP_WAIT: phase_next = PH_CONV;
          STEP_READ_PAD: begin
            phase_next = PH_WR_REC;
            shift_byte_next = READ_PAD;
          end
          STEP_LOW_BYTE, STEP_HI_BYTE: phase_next = PH_RD_REC;
          default: phase_next = PH_TAIL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_time       <= 10'd600;
      reset_release_time   <= 10'd70;
      presence_window_time <= 10'd240;
      write_slot_time      <= 8'd80;
      read_recovery_time   <= 8'd60;
      conversion_wait_time <= 20'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:     reset_low_time       <= cfg_data[9:0];
        REG_RESET_RELEASE: reset_release_time   <= cfg_data[9:0];
        REG_PRESENCE_WIN:  presence_window_time <= cfg_data[9:0];
        REG_WRITE_SLOT:    write_slot_time      <= cfg_data[7:0];
        REG_READ_RECOVERY: read_recovery_time   <= cfg_data[7:0];
        REG_CONV_WAIT:     conversion_wait_time <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_counter     <= '0;
      bit_counter      <= '0;
      shift_byte       <= '0;
      sequence_step    <= STEP_NONE;
      low_byte_hold    <= '0;
      temperature_hold <= '0;
      last_read        <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (in_beat) begin
        phase            <= phase_next;
        tick_counter     <= tick_counter_next;
        bit_counter      <= bit_counter_next;
        shift_byte       <= shift_byte_next;
        sequence_step    <= sequence_step_next;
        low_byte_hold    <= low_byte_hold_next;
        temperature_hold <= temperature_hold_next;
        last_read        <= last_read_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result beat register, loaded with each accepted tick
  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_tdata <= {3'b000, valid_flag, temperature_hold_next, last_read_next,
                  done_flag, busy, out_enable, drive_low};
    end
  end

endmodule
